// ===== rtl/pfcs_pkg.sv =====
`default_nettype none
package pfcs_pkg;

  localparam int HalfHeight = 360;
  // Quotient magnitude width: |column * height| reaches 2^25.
  localparam int NumW       = 26;
  // Depth magnitude width: |row - pitch| stays below 2^11.
  localparam int DivW       = 11;
  localparam int CellCount  = NumW;

  typedef enum logic [2:0] {
    RegPitch  = 3'd0,
    RegHeight = 3'd1,
    RegSin    = 3'd2,
    RegCos    = 3'd3,
    RegOffU   = 3'd4,
    RegOffV   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [10:0] pitch;
    logic signed [15:0] height;
    logic signed [15:0] sin_yaw;
    logic signed [15:0] cos_yaw;
    logic signed [23:0] off_u;
    logic signed [23:0] off_v;
  } cfg_t;

  // One pixel in flight through the divider row: partial remainders and
  // shifting numerator/quotient words for both floor coordinates.
  typedef struct packed {
    logic [DivW-1:0] rem_x;
    logic [NumW-1:0] acc_x;
    logic [DivW-1:0] rem_y;
    logic [NumW-1:0] acc_y;
    logic [DivW-1:0] dmag;
    logic            neg_x;
    logic            neg_y;
    logic            ok;
  } div_t;

  // One restoring step on a single coordinate: shift in the next numerator
  // bit, subtract when it fits, shift the quotient bit in at the bottom.
  function automatic logic [DivW+NumW-1:0] div_bit(input logic [DivW-1:0] rem,
                                                   input logic [NumW-1:0] acc,
                                                   input logic [DivW-1:0] d);
    logic [DivW:0]   r2;
    logic [DivW:0]   diff;
    logic [DivW-1:0] rem_n;
    logic            q;
    r2   = {rem, acc[NumW-1]};
    diff = r2 - {1'b0, d};
    if (r2 >= {1'b0, d}) begin
      rem_n = diff[DivW-1:0];
      q     = 1'b1;
    end else begin
      rem_n = r2[DivW-1:0];
      q     = 1'b0;
    end
    return {rem_n, acc[NumW-2:0], q};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/perspective_floor_checker_shader.sv =====
// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tdata: column[10:0], row[21:11], zero pad to 24 bits
// m_axis    out        tdata: shade[0], zero pad to 8 bits; tuser: valid_res
// cfg       in         cfg_index_i selects register, cfg_data_i holds value
//
// One pixel per clock sustained while m_axis is ready; 31 registers from input
// to output: one setup stage, 26 divider cells, four rotate/fold stages. The row
// of divider cells, one quotient bit per cell, makes up most of that depth.
// Reset clears all valid flags and loads the register defaults.
// Each stage moves when it is empty or the stage after it moves, so bubbles
// collapse and input keeps flowing into empty stages while a result waits on m_axis.
`default_nettype none
module perspective_floor_checker_shader (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // column[10:0], row[21:11]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // shade[0]
  output logic             m_axis_tuser,  // valid_res[0]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);

  localparam int N = pfcs_pkg::CellCount;

  pfcs_pkg::cfg_t cfg_q;

  // Configuration writes are always taken; unknown indexes drop.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pitch   <= '0;
      cfg_q.height  <= 16'sd512;
      cfg_q.sin_yaw <= '0;
      cfg_q.cos_yaw <= 16'sd16384;
      cfg_q.off_u   <= '0;
      cfg_q.off_v   <= '0;
    end else if (cfg_valid_i) begin
      unique case (pfcs_pkg::reg_idx_e'(cfg_index_i))
        pfcs_pkg::RegPitch:  cfg_q.pitch   <= cfg_data_i[10:0];
        pfcs_pkg::RegHeight: cfg_q.height  <= cfg_data_i[15:0];
        pfcs_pkg::RegSin:    cfg_q.sin_yaw <= cfg_data_i[15:0];
        pfcs_pkg::RegCos:    cfg_q.cos_yaw <= cfg_data_i[15:0];
        pfcs_pkg::RegOffU:   cfg_q.off_u   <= cfg_data_i;
        pfcs_pkg::RegOffV:   cfg_q.off_v   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Setup stage: depth, height products, magnitudes and quotient signs.
  logic signed [10:0] col_s, row_s;
  logic signed [11:0] dz;
  logic signed [15:0] h_eff;
  logic signed [26:0] px;
  logic signed [25:0] py;
  pfcs_pkg::div_t     front_d;

  always_comb begin
    col_s   = s_axis_tdata[10:0];
    row_s   = s_axis_tdata[21:11];
    dz      = 12'(row_s) - 12'(cfg_q.pitch);
    h_eff   = (cfg_q.height == 16'sd0) ? 16'sd1 : cfg_q.height;
    px      = 27'(col_s) * 27'(h_eff);
    py      = 26'(h_eff) * 26'(pfcs_pkg::HalfHeight);
    front_d.rem_x = '0;
    front_d.rem_y = '0;
    front_d.acc_x = px[26] ? 26'(-px) : 26'(px);
    front_d.acc_y = py[25] ? 26'(-py) : 26'(py);
    front_d.dmag  = dz[11] ? 11'(-dz) : 11'(dz);
    front_d.neg_x = px[26] ^ dz[11];
    front_d.neg_y = py[25] ^ dz[11];
    front_d.ok    = (dz != 12'sd0);
  end

  logic           v [N+1];
  logic           en [N+2];
  pfcs_pkg::div_t d [N+1];
  logic           back_ready;

  assign en[N+1] = back_ready;
  for (genvar k = 0; k <= N; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end

  assign s_axis_tready = en[0];

  logic           front_v_q;
  pfcs_pkg::div_t front_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_v_q <= 1'b0;
    end else if (en[0]) begin
      front_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      front_q <= front_d;
    end
  end

  assign v[0] = front_v_q;
  assign d[0] = front_q;

  // Divider row: each cell settles one quotient bit of both coordinates.
  for (genvar k = 1; k <= N; k++) begin : g_cell
    pfcs_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en[k]),
      .valid_i(v[k-1]),
      .data_i (d[k-1]),
      .valid_o(v[k]),
      .data_o (d[k])
    );
  end

  logic shade, valid_res;

  pfcs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .valid_i    (v[N]),
    .data_i     (d[N]),
    .ready_o    (back_ready),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .shade_o    (shade),
    .valid_res_o(valid_res)
  );

  assign m_axis_tdata = {7'd0, shade};
  assign m_axis_tuser = valid_res;

endmodule
`default_nettype wire

// ===== rtl/pfcs_div_cell.sv =====
`default_nettype none
module pfcs_div_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire pfcs_pkg::div_t data_i,
  output logic                valid_o,
  output pfcs_pkg::div_t      data_o
);

  logic           valid_q;
  pfcs_pkg::div_t data_q, data_d;

  always_comb begin
    data_d = data_i;
    {data_d.rem_x, data_d.acc_x} = pfcs_pkg::div_bit(data_i.rem_x, data_i.acc_x, data_i.dmag);
    {data_d.rem_y, data_d.acc_y} = pfcs_pkg::div_bit(data_i.rem_y, data_i.acc_y, data_i.dmag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// ===== rtl/pfcs_back.sv =====
`default_nettype none
module pfcs_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire pfcs_pkg::cfg_t cfg_i,
  input  wire logic           valid_i,
  input  wire pfcs_pkg::div_t data_i,
  output logic                ready_o,
  output logic                valid_o,
  input  wire logic           ready_i,
  output logic                shade_o,
  output logic                valid_res_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic e1, e2, e3, e4;

  logic signed [26:0] fx_q, fy_q;
  logic               ok1_q, ok2_q, ok3_q;
  logic signed [42:0] pu1_q, pu2_q, pv1_q, pv2_q;
  logic signed [30:0] u_q, v_q;
  logic               shade_q, res_q;

  logic signed [26:0] fx_d, fy_d;
  logic signed [43:0] du, dv;
  logic signed [30:0] u_d, v_d;
  logic signed [31:0] uf, vf;

  assign e4      = !v4_q || ready_i;
  assign e3      = !v3_q || e4;
  assign e2      = !v2_q || e3;
  assign e1      = !v1_q || e2;
  assign ready_o = e1;

  // Restore signs of the truncated quotients.
  always_comb begin
    fx_d = data_i.neg_x ? -$signed({1'b0, data_i.acc_x}) : $signed({1'b0, data_i.acc_x});
    fy_d = data_i.neg_y ? -$signed({1'b0, data_i.acc_y}) : $signed({1'b0, data_i.acc_y});
  end

  // Rotate, floor by 2^14, remove camera offsets.
  always_comb begin
    du  = 44'(pu1_q) - 44'(pu2_q);
    dv  = 44'(pv1_q) + 44'(pv2_q);
    u_d = 31'($signed(du[43:14])) - 31'(cfg_i.off_u);
    v_d = 31'($signed(dv[43:14])) - 31'(cfg_i.off_v);
  end

  // Fold negatives to minus the value plus one.
  always_comb begin
    uf = u_q[30] ? (-32'(u_q) + 32'sd256) : 32'(u_q);
    vf = v_q[30] ? (-32'(v_q) + 32'sd256) : 32'(v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (e1) v1_q <= valid_i;
      if (e2) v2_q <= v1_q;
      if (e3) v3_q <= v2_q;
      if (e4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e1) begin
      fx_q  <= fx_d;
      fy_q  <= fy_d;
      ok1_q <= data_i.ok;
    end
    if (e2) begin
      pu1_q <= fx_q * cfg_i.sin_yaw;
      pu2_q <= fy_q * cfg_i.cos_yaw;
      pv1_q <= fx_q * cfg_i.cos_yaw;
      pv2_q <= fy_q * cfg_i.sin_yaw;
      ok2_q <= ok1_q;
    end
    if (e3) begin
      u_q   <= u_d;
      v_q   <= v_d;
      ok3_q <= ok2_q;
    end
    if (e4) begin
      shade_q <= ok3_q && (uf[8] == vf[8]);
      res_q   <= ok3_q;
    end
  end

  assign valid_o     = v4_q;
  assign shade_o     = shade_q;
  assign valid_res_o = res_q;

endmodule
`default_nettype wire

// ===== rtl/pfcs_checker.sv =====
`default_nettype none
module pfcs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [23:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic [2:0]  cfg_index_i,
  input wire logic [23:0] cfg_data_i
);

  // A held result keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // With the output free, the whole pipe drains, so input is taken.
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with output empty");

  // Zero depth carries no colour.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 8'd0)
    else $error("invalid pixel carries shade");

  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind perspective_floor_checker_shader pfcs_checker u_pfcs_checker (.*);
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Indexes past the register file; writes there must change nothing.
  localparam logic [2:0] SpareIdxLo = 3'd6;
  localparam logic [2:0] SpareIdxHi = 3'd7;
  localparam int SettleCycles = 40;      // pipeline depth plus margin
  localparam int IdleLimit    = 5000;    // cycles with no transfer at all

  typedef struct packed {
    logic shade;
    logic valid_res;
  } pixel_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;    // column[10:0], row[21:11]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // shade[0]
  logic        m_axis_tuser;         // valid_res[0]
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  perspective_floor_checker_shader dut (.*);

  always #5 clk_i = ~clk_i;

  // Camera settings as the block should hold them.
  pfcs_pkg::cfg_t camera;
  pixel_res_t     shade_q[$];
  int             err_count = 0;
  int             pixels_sent = 0;
  int             pixels_seen = 0;
  int             cfg_writes = 0;
  int             burst_left = 0;

  // Parity of the integer part after folding negatives to -c + 1.0.
  function automatic logic fold_parity(input longint coord);
    if (coord < 0) coord = -coord + 256;
    return coord[8];
  endfunction

  // Project a pixel onto the floor, rotate, offset, and pick the checker color.
  function automatic pixel_res_t shade_pixel(input logic [10:0] col_b,
                                             input logic [10:0] row_b);
    longint col, row, h, dz, fx, fy, u, v;
    pixel_res_t r;
    col = longint'($signed(col_b));
    row = longint'($signed(row_b));
    dz  = row - longint'(camera.pitch);
    h   = longint'(camera.height);
    if (h == 0) h = 1;
    if (dz == 0) begin
      r.shade = 1'b0;
      r.valid_res = 1'b0;
      return r;
    end
    // SystemVerilog division truncates toward zero, arithmetic shift floors.
    fx = (col * h) / dz;
    fy = (longint'(pfcs_pkg::HalfHeight) * h) / dz;
    u  = ((fx * longint'(camera.sin_yaw) - fy * longint'(camera.cos_yaw)) >>> 14)
         - longint'(camera.off_u);
    v  = ((fx * longint'(camera.cos_yaw) + fy * longint'(camera.sin_yaw)) >>> 14)
         - longint'(camera.off_v);
    r.shade = (fold_parity(u) == fold_parity(v));
    r.valid_res = 1'b1;
    return r;
  endfunction

  // Drive one pixel; the stream runs in bursts with random gaps in between.
  task automatic send_pixel(input logic [10:0] col, input logic [10:0] row);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, row, col};
    do @(posedge clk_i); while (!s_axis_tready);
    // Predict at the transfer edge, with the settings in force for this pixel.
    shade_q.insert(shade_q.size(), shade_pixel(col, row));
    pixels_sent++;
  endtask

  // Drain everything in flight so registers can be written safely.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (shade_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    cfg_writes++;
    case (idx)
      pfcs_pkg::RegPitch:  camera.pitch   = data[10:0];
      pfcs_pkg::RegHeight: camera.height  = data[15:0];
      pfcs_pkg::RegSin:    camera.sin_yaw = data[15:0];
      pfcs_pkg::RegCos:    camera.cos_yaw = data[15:0];
      pfcs_pkg::RegOffU:   camera.off_u   = data[23:0];
      pfcs_pkg::RegOffV:   camera.off_v   = data[23:0];
      default: ;  // spare index: ignore
    endcase
  endtask

  task automatic set_camera(input logic [23:0] pitch, input logic [23:0] height,
                            input logic [23:0] s, input logic [23:0] c,
                            input logic [23:0] ou, input logic [23:0] ov);
    wait_drained();
    write_reg(pfcs_pkg::RegPitch, pitch);
    write_reg(pfcs_pkg::RegHeight, height);
    write_reg(pfcs_pkg::RegSin, s);
    write_reg(pfcs_pkg::RegCos, c);
    write_reg(pfcs_pkg::RegOffU, ou);
    write_reg(pfcs_pkg::RegOffV, ov);
  endtask

  // Pick a register value: extremes, zero, in-range, or any 24-bit pattern.
  function automatic logic [23:0] pick_value(input int lo, input int hi);
    case ($urandom_range(0, 5))
      0: return 24'(lo);
      1: return 24'(hi);
      2: return 24'($urandom);
      3: return 24'(0);
      default: return 24'(lo + int'($urandom_range(0, hi - lo)));
    endcase
  endfunction

  // Default settings straight after reset, field extremes included.
  task automatic test_reset_defaults();
    send_pixel(11'd0, 11'd1);
    send_pixel(11'h400, 11'h3ff);        // most negative column, top row
    send_pixel(11'h3ff, 11'h400);        // most positive column, bottom row
    send_pixel(11'h258, 11'd100);
    send_pixel(11'h7ff, 11'h7ff);
    send_pixel(11'h555, 11'h2aa);
    send_pixel(11'h2aa, 11'h555);
    send_pixel(11'd17, 11'd0);           // row equals reset pitch: no depth
  endtask

  // Zero depth at extreme pitch, zero height replaced by one LSB, and
  // writes to spare indexes that must leave the camera untouched.
  task automatic test_special_cases();
    set_camera(24'h000400, 24'h0, 24'h002d41, 24'h002d41, 24'h0, 24'h0);
    send_pixel(11'h3ff, 11'h400);        // row == pitch
    send_pixel(11'h400, 11'h401);
    send_pixel(11'd300, 11'h3ff);
    set_camera(24'h0003ff, 24'h008000, 24'h00c000, 24'h004000,
               24'h800000, 24'h7fffff);
    write_reg(SpareIdxLo, 24'hffffff);
    write_reg(SpareIdxHi, 24'h123456);
    send_pixel(11'd5, 11'h3ff);          // row == pitch
    send_pixel(11'h400, 11'h400);
    send_pixel(11'h3ff, 11'h3fe);
    set_camera(24'hfffc00, 24'h007fff, 24'h004000, 24'h00c000,
               24'h7fffff, 24'h800000);
    send_pixel(11'h400, 11'h3ff);
    send_pixel(11'h3ff, 11'h401);
    send_pixel(11'd0, 11'd0);
  endtask

  // Random camera settings, each followed by a run of random pixels.
  task automatic test_random_frames(input int frames, input int per_frame);
    logic [10:0] col, row;
    for (int f = 0; f < frames; f++) begin
      set_camera(pick_value(-720, 720), pick_value(-32768, 32767),
                 pick_value(-16384, 16384), pick_value(-16384, 16384),
                 pick_value(-8388608, 8388607), pick_value(-8388608, 8388607));
      for (int i = 0; i < per_frame; i++) begin
        col = 11'($urandom);
        row = 11'($urandom);
        case ($urandom_range(0, 9))
          0: row = camera.pitch;                          // no depth
          1: row = camera.pitch + 11'($urandom_range(0, 2)) - 11'd1;
          2: col = $urandom_range(0, 1) ? 11'h400 : 11'h3ff;
          default: ;
        endcase
        send_pixel(col, row);
      end
    end
  endtask

  // Receiver: stall on a pattern whose mode is redrawn at random while the bench runs.
  int unsigned stall_mode = 0;
  int unsigned rx_cycle = 0;
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= (rx_cycle % 4 == 0);
      default: m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    pixel_res_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      pixels_seen++;
      if (shade_q.size() == 0) begin
        $error("result with no pixel outstanding: shade %0b valid_res %0b",
               m_axis_tdata[0], m_axis_tuser);
        err_count++;
      end else begin
        exp_r = shade_q.pop_front();
        if (m_axis_tdata[0] !== exp_r.shade) begin
          $error("shade: expected %0b, got %0b", exp_r.shade, m_axis_tdata[0]);
          err_count++;
        end
        if (m_axis_tuser !== exp_r.valid_res) begin
          $error("valid_res: expected %0b, got %0b", exp_r.valid_res, m_axis_tuser);
          err_count++;
        end
        if (m_axis_tdata[7:1] !== 7'd0) begin
          $error("tdata pad: expected 0, got %0h", m_axis_tdata[7:1]);
          err_count++;
        end
      end
    end
  end

  // Watchdog: give up after a long stretch with no transfer on any channel.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: %0d cycles without a transfer", IdleLimit);
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    camera = '{pitch: 11'sd0, height: 16'sd512, sin_yaw: 16'sd0,
               cos_yaw: 16'sd16384, off_u: 24'sd0, off_v: 24'sd0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_special_cases();
    test_random_frames(8, 235);
    wait_drained();
    $display("covered %0d pixels, %0d results, %0d register writes incl. spare indexes",
             pixels_sent, pixels_seen, cfg_writes);
    $display("zero depth, zero height, extreme pitch/yaw/offsets, bursty input, stalls");
    if (err_count == 0 && shade_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      if (shade_q.size() != 0) $error("%0d results never arrived", shade_q.size());
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
